>>> rtl/core/sbg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbg_pkg
// Shared types and constants of the subtract-with-borrow generator.
// ----------------------------------------------------------------------------
package sbg_pkg;

  localparam int LONG_LAG_DEF  = 920;
  localparam int SHORT_LAG_DEF = 856;
  localparam int WORD_W        = 32;
  localparam int POS_W         = 10;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_GENERATE = 1'b1
  } op_t;

endpackage
`default_nettype wire

>>> rtl/core/sbg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbg_if
// Item channels of the generator: command in, random word out.
// ----------------------------------------------------------------------------
interface sbg_in_if;
  logic                          valid;
  logic                          ready;
  sbg_pkg::op_t                  operation;
  logic [sbg_pkg::POS_W-1:0]     load_position;
  logic [sbg_pkg::WORD_W-1:0]    load_word;

  modport source (output valid, operation, load_position, load_word, input ready);
  modport sink   (input valid, operation, load_position, load_word, output ready);
endinterface

interface sbg_out_if;
  logic                          valid;
  logic                          ready;
  logic [sbg_pkg::WORD_W-1:0]    random_word;

  modport source (output valid, random_word, input ready);
  modport sink   (input valid, random_word, output ready);
endinterface
`default_nettype wire

>>> rtl/core/sbg_lag_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbg_lag_ram
// Lag word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sbg_lag_ram #(
  parameter int DEPTH = sbg_pkg::LONG_LAG_DEF + 1,
  parameter int AW    = $clog2(sbg_pkg::LONG_LAG_DEF + 1),
  parameter int DW    = sbg_pkg::WORD_W
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/subtract_with_borrow_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// subtract_with_borrow_generator
// Lagged subtract-with-borrow generator on 32-bit words held in lag memory.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | accepted when
//  cmd     | in  | operation, load_position, load_word      | valid && ready
//  rnd     | out | random_word                              | valid && ready
//
//  One item per cycle sustained while cmd does not stall. An item reads both
//  lag words at accept; s1 then computes and writes back, via two memory
//  copies (one read port each, shared write); a write to a just-read entry is
//  forwarded. A generate result then goes from s1 to the output register.
//  Reset loads the pointers with the lags, sets the borrow and clears control;
//  the lag memory is undefined until loaded, with no clearing pass. cmd stalls
//  only while a generate item waits on a full, untaken output register.
// ----------------------------------------------------------------------------
module subtract_with_borrow_generator #(
  parameter int LONG_LAG  = sbg_pkg::LONG_LAG_DEF,
  parameter int SHORT_LAG = sbg_pkg::SHORT_LAG_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  sbg_in_if.sink      cmd,
  sbg_out_if.source   rnd
);

  localparam int AW = $clog2(LONG_LAG + 1);
  localparam int DW = sbg_pkg::WORD_W;

  logic [AW-1:0] long_ptr;
  logic [AW-1:0] short_ptr;
  logic          borrow;
  logic          fix1;
  logic          fix2;

  logic          s1_valid;
  sbg_pkg::op_t  s1_op;
  logic [AW-1:0] s1_rd_short;
  logic [AW-1:0] s1_rd_long;
  logic [AW-1:0] s1_wr_addr;
  logic          s1_wr_en;
  logic [DW-1:0] s1_load_word;

  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  logic [DW-1:0] fwd_data;

  logic          out_valid;
  logic [DW-1:0] out_word;

  logic          accept;
  logic          s1_gen;
  logic          s1_move;
  logic          in_range;
  logic [DW-1:0] mem_short;
  logic [DW-1:0] mem_long;
  logic [DW-1:0] word_a;
  logic [DW-1:0] word_b;
  logic [DW:0]   diff;
  logic          we;
  logic [DW-1:0] wdata;

  function automatic logic [AW-1:0] count_down(input logic [AW-1:0] p);
    return (p <= AW'(1)) ? AW'(LONG_LAG) : p - AW'(1);
  endfunction

  function automatic logic [DW-1:0] lag_word(
    input logic [DW-1:0] mem_q,
    input logic [AW-1:0] addr,
    input logic          fv,
    input logic [AW-1:0] fa,
    input logic [DW-1:0] fd,
    input logic          f1,
    input logic          f2
  );
    logic [DW-1:0] w;
    w = (fv && fa == addr) ? fd : mem_q;
    if (f1 && addr == AW'(1)) begin
      w[0] = 1'b1;
    end
    if (f2 && addr == AW'(2)) begin
      w[0] = 1'b0;
    end
    return w;
  endfunction

  assign s1_gen     = (s1_op == sbg_pkg::OP_GENERATE);
  assign s1_move    = s1_valid && (!s1_gen || !out_valid || rnd.ready);
  assign cmd.ready  = !s1_valid || s1_move;
  assign accept     = cmd.valid && cmd.ready;
  assign in_range   = (cmd.load_position != '0) &&
                      (cmd.load_position <= sbg_pkg::POS_W'(LONG_LAG));

  assign word_a = lag_word(mem_short, s1_rd_short, fwd_valid, fwd_addr, fwd_data, fix1, fix2);
  assign word_b = lag_word(mem_long, s1_rd_long, fwd_valid, fwd_addr, fwd_data, fix1, fix2);
  assign diff   = {1'b0, word_a} - {1'b0, word_b} - {{DW{1'b0}}, borrow};

  assign we    = s1_move && (s1_gen || s1_wr_en);
  assign wdata = s1_gen ? diff[DW-1:0] : s1_load_word;

  assign rnd.valid       = out_valid;
  assign rnd.random_word = out_word;

  sbg_lag_ram #(.DEPTH(LONG_LAG + 1), .AW(AW), .DW(DW)) u_ram_short (
    .clk   (clk),
    .we    (we),
    .waddr (s1_wr_addr),
    .wdata (wdata),
    .re    (accept),
    .raddr (short_ptr),
    .rdata (mem_short)
  );

  sbg_lag_ram #(.DEPTH(LONG_LAG + 1), .AW(AW), .DW(DW)) u_ram_long (
    .clk   (clk),
    .we    (we),
    .waddr (s1_wr_addr),
    .wdata (wdata),
    .re    (accept),
    .raddr (long_ptr),
    .rdata (mem_long)
  );

  // front: pointers count down, or reload on a load, at accept
  always_ff @(posedge clk) begin
    if (rst) begin
      long_ptr  <= AW'(LONG_LAG);
      short_ptr <= AW'(SHORT_LAG);
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (cmd.operation == sbg_pkg::OP_LOAD) begin
          long_ptr  <= AW'(LONG_LAG);
          short_ptr <= AW'(SHORT_LAG);
        end else begin
          long_ptr  <= count_down(long_ptr);
          short_ptr <= count_down(short_ptr);
        end
        fwd_valid <= we;
        s1_valid  <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op        <= cmd.operation;
      s1_rd_short  <= short_ptr;
      s1_rd_long   <= long_ptr;
      s1_load_word <= cmd.load_word;
      fwd_addr     <= s1_wr_addr;
      fwd_data     <= wdata;
      if (cmd.operation == sbg_pkg::OP_LOAD) begin
        s1_wr_addr <= cmd.load_position[AW-1:0];
        s1_wr_en   <= in_range;
      end else begin
        s1_wr_addr <= long_ptr;
        s1_wr_en   <= 1'b1;
      end
    end
  end

  // commit: borrow, bit-0 fixes, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      borrow    <= 1'b1;
      fix1      <= 1'b0;
      fix2      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_move && s1_gen) begin
        borrow    <= diff[DW];
        out_valid <= 1'b1;
        if (s1_wr_addr == AW'(1)) begin
          fix1 <= 1'b0;
        end
        if (s1_wr_addr == AW'(2)) begin
          fix2 <= 1'b0;
        end
      end else begin
        if (rnd.ready) begin
          out_valid <= 1'b0;
        end
        if (s1_move) begin
          borrow <= 1'b1;
          fix1   <= 1'b1;
          fix2   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_gen) begin
      out_word <= diff[DW-1:0];
    end
  end

endmodule
`default_nettype wire
